FILE: rtl/core/timed_blind_position_tracker_unit_macros.svh
// Assertion macros for the timed blind position tracker.
// Used by every module of the block; needs clk and arst_n in scope.
`ifndef TIMED_BLIND_POSITION_TRACKER_UNIT_MACROS_SVH
`define TIMED_BLIND_POSITION_TRACKER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TBPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TBPT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define TBPT_ASSERT(lbl, prop, msg)
`define TBPT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/core/tbpt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the timed blind position tracker.
// No dependencies.
package tbpt_pkg;

	localparam int POS_W     = 7;
	localparam int DUR_W     = 22;
	localparam int PROD_W    = DUR_W + POS_W;
	localparam int TIME_W    = 32;
	localparam int TRAVEL_W  = 12;
	localparam int STEP_W    = $clog2(POS_W);

	localparam logic [POS_W-1:0]  FULL_POS      = 7'd100;
	localparam logic [DUR_W-1:0]  MIN_MOVE_MS   = 22'd300;
	localparam logic [TIME_W-1:0] REPORT_GAP_MS = 32'd500;

	typedef enum logic [2:0] {
		FN_OPEN   = 3'd0,
		FN_CLOSE  = 3'd1,
		FN_SETPOS = 3'd2,
		FN_STOP   = 3'd3,
		FN_TICK   = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		MS_OPEN    = 2'd0,
		MS_CLOSED  = 2'd1,
		MS_OPENING = 2'd2,
		MS_CLOSING = 2'd3
	} motion_t;

	typedef enum logic [1:0] {
		CFG_OPEN_TRAVEL  = 2'd0,
		CFG_CLOSE_TRAVEL = 2'd1,
		CFG_SNAP_CLOSED  = 2'd2,
		CFG_SNAP_OPEN    = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_STOP,
		ACT_START,
		ACT_TICK
	} act_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ARITH,
		S_MUL,
		S_DIV,
		S_FINISH,
		S_EMIT
	} state_t;

	localparam logic KIND_RADIO  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic             kind;
		logic             rf_open;
		logic             rf_long;
		logic [1:0]       st;
		logic [POS_W-1:0] pos;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic result_t radio_res(input logic open_dir, input logic long_press);
		result_t r;
		r.kind    = KIND_RADIO;
		r.rf_open = open_dir;
		r.rf_long = long_press;
		r.st      = 2'd0;
		r.pos     = '0;
		return r;
	endfunction

	function automatic result_t report_res(input logic [1:0] st, input logic [POS_W-1:0] pos);
		result_t r;
		r.kind    = KIND_REPORT;
		r.rf_open = 1'b0;
		r.rf_long = 1'b0;
		r.st      = st;
		r.pos     = pos;
		return r;
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W:0] v);
		return (v > {1'b0, FULL_POS}) ? FULL_POS : v[POS_W-1:0];
	endfunction

endpackage

FILE: rtl/core/tbpt_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tbpt_pkg and the assertion macro header.
`include "timed_blind_position_tracker_unit_macros.svh"
module tbpt_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tbpt_pkg::DUR_W-1:0]      a,
	input  logic [tbpt_pkg::POS_W-1:0]      b,
	output tbpt_pkg::unit_stat_t            stat,
	output logic [tbpt_pkg::PROD_W-1:0]     prod
);
	import tbpt_pkg::*;

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] mcand_q;
	logic [POS_W-1:0]  mplier_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(POS_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= PROD_W'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[POS_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign prod      = acc_q;

	`TBPT_ASSERT(a_mul_start_idle, start |-> !busy_q, "multiplier started while busy")

endmodule

FILE: rtl/core/tbpt_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; quotient fits POS_W bits.
// Depends on tbpt_pkg and the assertion macro header.
`include "timed_blind_position_tracker_unit_macros.svh"
module tbpt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tbpt_pkg::PROD_W-1:0]     num,
	input  logic [tbpt_pkg::DUR_W-1:0]      den,
	output tbpt_pkg::unit_stat_t            stat,
	output logic [tbpt_pkg::POS_W-1:0]      quot
);
	import tbpt_pkg::*;

	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dvs_q;
	logic [POS_W-1:0]  quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = (rem_q >= dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(POS_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dvs_q  <= PROD_W'({den, {(POS_W - 1){1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - dvs_q;
			quot_q <= {quot_q[POS_W-2:0], fits};
			dvs_q  <= {1'b0, dvs_q[PROD_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

	`TBPT_ASSERT(a_div_start_idle, start |-> !busy_q, "divider started while busy")

endmodule

FILE: rtl/core/timed_blind_position_tracker_unit.sv
`timescale 1ns / 1ps
// Timed blind position tracker: one command transaction at a time, up to three results.
// A move start passes through decode and the serial multiplier; a stop or tick that
// interpolates passes through decode, the multiplier and then the divider. Results then
// leave one per cycle while the consumer keeps up. A new command is taken only once the
// last result of the previous one is emitted; an ignored command goes straight back to idle.
// Reset (asynchronous): travel 30 s both ways, snaps 5 and 95, position 50, idle.
`include "timed_blind_position_tracker_unit_macros.svh"
module timed_blind_position_tracker_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [1:0]                      cfg_index,
	input  logic [tbpt_pkg::TRAVEL_W-1:0]   cfg_data,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  logic [2:0]                      func,
	input  logic [7:0]                      goal_percent,
	input  logic [tbpt_pkg::TIME_W-1:0]     now_ms,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic                            result_kind,
	output logic                            rf_open,
	output logic                            rf_long,
	output logic [1:0]                      report_state,
	output logic [tbpt_pkg::POS_W-1:0]      report_pos,
	output logic                            last
);
	import tbpt_pkg::*;

	// configuration
	logic [TRAVEL_W-1:0] open_travel_q, close_travel_q;
	logic [POS_W-1:0]    snap_closed_q, snap_open_q;

	// tracker state
	logic [POS_W-1:0]  position_q, from_q, to_q;
	logic [TIME_W-1:0] start_time_q, last_rep_q;
	logic [DUR_W-1:0]  len_q;
	logic              moving_q, partial_q, heading_q;
	logic [1:0]        motion_q;

	// transaction and work registers
	state_t            state_q, state_d;
	logic [2:0]        func_q;
	logic [7:0]        goal_q;
	logic [TIME_W-1:0] now_q;
	act_t              act_q, act_d;
	logic              go_open_q, go_open_d;
	logic              go_partial_q, go_partial_d;
	logic [POS_W-1:0]  target_q, target_d;
	logic [TIME_W-1:0] elapsed_q;
	logic              due_q, complete_q, up_q;
	logic [POS_W-1:0]  pos_calc_q;
	logic [DUR_W-1:0]  dur_calc_q;
	result_t           res_q [3];
	result_t           res_d [3];
	logic [1:0]        n_q, n_d, idx_q;

	// output register
	logic              res_valid_q;
	result_t           out_q;
	logic              last_q;

	// units
	logic              mul_start, div_start;
	unit_stat_t        mul_stat, div_stat;
	logic [DUR_W-1:0]  mul_a;
	logic [POS_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_prod;
	logic [POS_W-1:0]  div_quot;

	logic              slot_free, emit, accept;
	logic [POS_W-1:0]  goal_clamped, snap_goal, span, diff, to_clamped;
	logic [DUR_W-1:0]  e_len;
	logic [TIME_W-1:0] dur_ten;
	logic              opposite;

	assign accept    = cmd_valid && cmd_ready;
	assign slot_free = !res_valid_q || res_ready;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_travel_q  <= 12'd30;
			close_travel_q <= 12'd30;
			snap_closed_q  <= 7'd5;
			snap_open_q    <= 7'd95;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_OPEN_TRAVEL:  open_travel_q  <= cfg_data;
				CFG_CLOSE_TRAVEL: close_travel_q <= cfg_data;
				CFG_SNAP_CLOSED:  snap_closed_q  <= cfg_data[POS_W-1:0];
				CFG_SNAP_OPEN:    snap_open_q    <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---- command decode ----
	always_comb begin
		goal_clamped = (goal_q > {1'b0, FULL_POS}) ? FULL_POS : goal_q[POS_W-1:0];
		if (goal_clamped <= snap_closed_q)
			snap_goal = '0;
		else if (goal_clamped >= snap_open_q)
			snap_goal = FULL_POS;
		else
			snap_goal = goal_clamped;

		opposite = 1'b0;
		if (moving_q) begin
			case (func_q)
				FN_OPEN:   opposite = (motion_q == MS_CLOSING);
				FN_CLOSE:  opposite = (motion_q == MS_OPENING);
				FN_SETPOS: opposite = (snap_goal != position_q) &&
					((snap_goal > position_q) != (motion_q == MS_OPENING));
				default:   opposite = 1'b0;
			endcase
		end

		act_d        = ACT_NONE;
		go_open_d    = 1'b0;
		go_partial_d = 1'b0;
		target_d     = '0;
		case (func_q)
			FN_TICK: if (moving_q) act_d = ACT_TICK;
			FN_STOP: if (moving_q) act_d = ACT_STOP;
			FN_OPEN, FN_CLOSE, FN_SETPOS: begin
				if (opposite) begin
					act_d = ACT_STOP;
				end else if (func_q == FN_OPEN) begin
					act_d     = ACT_START;
					go_open_d = 1'b1;
					target_d  = FULL_POS;
				end else if (func_q == FN_CLOSE) begin
					act_d = ACT_START;
				end else if (snap_goal == '0) begin
					act_d = ACT_START;
				end else if (snap_goal == FULL_POS) begin
					act_d     = ACT_START;
					go_open_d = 1'b1;
					target_d  = FULL_POS;
				end else if ((snap_goal > position_q + 7'd1) ||
						(position_q > snap_goal + 7'd1)) begin
					act_d        = ACT_START;
					go_open_d    = (snap_goal > position_q);
					go_partial_d = 1'b1;
					target_d     = snap_goal;
				end
			end
			default: act_d = ACT_NONE;
		endcase
	end

	// ---- arithmetic operands ----
	assign span       = (target_q > position_q) ? target_q - position_q : position_q - target_q;
	assign diff       = (to_q >= from_q) ? to_q - from_q : from_q - to_q;
	assign e_len      = (elapsed_q < TIME_W'(len_q)) ? elapsed_q[DUR_W-1:0] : len_q;
	assign mul_a      = (act_q == ACT_START) ?
		DUR_W'(go_open_q ? open_travel_q : close_travel_q) : e_len;
	assign mul_b      = (act_q == ACT_START) ? span : diff;
	assign dur_ten    = TIME_W'({mul_prod, 3'b000}) + TIME_W'({mul_prod, 1'b0});
	assign to_clamped = clamp_pos({1'b0, to_q});

	tbpt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.prod   (mul_prod)
	);

	tbpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_prod),
		.den    (len_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// ---- result list ----
	always_comb begin
		logic [1:0] k;
		k = '0;
		for (int i = 0; i < 3; i++)
			res_d[i] = '0;
		case (act_q)
			ACT_STOP: begin
				res_d[0] = radio_res(motion_q != MS_OPENING, 1'b0);
				res_d[1] = report_res((pos_calc_q == '0) ? MS_CLOSED : MS_OPEN, pos_calc_q);
				k = 2'd2;
			end
			ACT_START: begin
				res_d[0] = radio_res(go_open_q, 1'b1);
				res_d[1] = report_res(go_open_q ? MS_OPENING : MS_CLOSING, position_q);
				k = 2'd2;
			end
			ACT_TICK: begin
				if (due_q) begin
					res_d[k] = report_res(motion_q, pos_calc_q);
					k = k + 2'd1;
				end
				if (complete_q) begin
					if (partial_q) begin
						res_d[k] = radio_res(!heading_q, 1'b0);
						k = k + 2'd1;
					end
					res_d[k] = report_res((to_clamped == '0) ? MS_CLOSED : MS_OPEN,
						to_clamped);
					k = k + 2'd1;
				end
			end
			default: k = '0;
		endcase
		n_d = k;
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_ready = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		emit      = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid)
					state_d = S_DECODE;
			end
			S_DECODE: state_d = (act_d == ACT_NONE) ? S_IDLE : S_ARITH;
			S_ARITH: begin
				if (act_q != ACT_START && len_q == '0) begin
					state_d = S_FINISH;
				end else begin
					mul_start = 1'b1;
					state_d   = S_MUL;
				end
			end
			S_MUL: begin
				if (mul_stat.done) begin
					if (act_q == ACT_START) begin
						state_d = S_FINISH;
					end else begin
						div_start = 1'b1;
						state_d   = S_DIV;
					end
				end
			end
			S_DIV: if (div_stat.done) state_d = S_FINISH;
			S_FINISH: state_d = (n_d == '0) ? S_IDLE : S_EMIT;
			S_EMIT: begin
				if (slot_free) begin
					emit = 1'b1;
					if (idx_q == n_q - 2'd1)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---- work registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			goal_q <= goal_percent;
			now_q  <= now_ms;
		end
		if (state_q == S_DECODE) begin
			act_q        <= act_d;
			go_open_q    <= go_open_d;
			go_partial_q <= go_partial_d;
			target_q     <= target_d;
			elapsed_q    <= now_q - start_time_q;
			due_q        <= (now_q - last_rep_q) > REPORT_GAP_MS;
		end
		if (state_q == S_ARITH) begin
			complete_q <= elapsed_q >= TIME_W'(len_q);
			up_q       <= to_q >= from_q;
			if (len_q == '0)
				pos_calc_q <= clamp_pos({1'b0, (act_q == ACT_STOP) ? from_q : to_q});
		end
		if (state_q == S_MUL && mul_stat.done)
			dur_calc_q <= (dur_ten < TIME_W'(MIN_MOVE_MS)) ? MIN_MOVE_MS : dur_ten[DUR_W-1:0];
		if (state_q == S_DIV && div_stat.done)
			pos_calc_q <= up_q ? clamp_pos({1'b0, from_q} + {1'b0, div_quot}) :
				clamp_pos({1'b0, from_q} - {1'b0, div_quot});
		if (state_q == S_FINISH) begin
			for (int i = 0; i < 3; i++)
				res_q[i] <= res_d[i];
			n_q   <= n_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (state_q == S_FINISH)
			idx_q <= '0;
		else if (emit)
			idx_q <= idx_q + 2'd1;
	end

	// ---- tracker state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= 7'd50;
			from_q       <= 7'd50;
			to_q         <= 7'd50;
			start_time_q <= '0;
			len_q        <= '0;
			moving_q     <= 1'b0;
			partial_q    <= 1'b0;
			heading_q    <= 1'b0;
			motion_q     <= MS_OPEN;
			last_rep_q   <= '0;
		end else if (state_q == S_FINISH) begin
			case (act_q)
				ACT_STOP: begin
					position_q <= pos_calc_q;
					moving_q   <= 1'b0;
					partial_q  <= 1'b0;
					motion_q   <= (pos_calc_q == '0) ? MS_CLOSED : MS_OPEN;
				end
				ACT_START: begin
					moving_q     <= 1'b1;
					partial_q    <= go_partial_q;
					heading_q    <= go_open_q;
					motion_q     <= go_open_q ? MS_OPENING : MS_CLOSING;
					from_q       <= position_q;
					to_q         <= target_q;
					start_time_q <= now_q;
					len_q        <= dur_calc_q;
				end
				ACT_TICK: begin
					if (due_q)
						last_rep_q <= now_q;
					if (complete_q) begin
						moving_q   <= 1'b0;
						partial_q  <= 1'b0;
						position_q <= to_clamped;
						motion_q   <= (to_clamped == '0) ? MS_CLOSED : MS_OPEN;
					end
				end
				default: ;
			endcase
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (emit)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q  <= res_q[idx_q];
			last_q <= (idx_q == n_q - 2'd1);
		end
	end

	assign res_valid    = res_valid_q;
	assign result_kind  = out_q.kind;
	assign rf_open      = out_q.rf_open;
	assign rf_long      = out_q.rf_long;
	assign report_state = out_q.st;
	assign report_pos   = out_q.pos;
	assign last         = last_q;

	`TBPT_ASSERT(a_moving_dir, moving_q |-> (motion_q == MS_OPENING || motion_q == MS_CLOSING), "moving without direction")
	`TBPT_ASSERT(a_rest_state, !moving_q |-> (motion_q == MS_OPEN || motion_q == MS_CLOSED), "at rest in a moving state")
	`TBPT_ASSERT(a_pos_range, position_q <= FULL_POS, "position above full open")
	`TBPT_ASSERT_NEXT(a_accept_decode, accept, state_q == S_DECODE, "accepted transaction not decoded")

endmodule
